### src/rsfl_pkg.sv
// rsfl_pkg: shared widths, codes and types for the record slot free list.
// No dependencies; imported by every module of the block.
package rsfl_pkg;

  // Field widths of the stream payload
  localparam int MODE_W    = 2;
  localparam int ID_W      = 10;
  localparam int BLK_W     = 11;
  localparam int OFF_W     = 22;
  localparam int ST_W      = 2;
  localparam int IN_DATA_W = 16;  // slot_id padded to whole bytes
  localparam int OUT_W     = 48;  // 47 result bits padded to whole bytes

  // Configuration
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;
  localparam int PER_W     = 11;
  localparam int BYTES_W   = 13;
  localparam int BLKCNT_W  = 12;  // block count never passes 2048

  localparam logic [PER_W-1:0]   PER_MAX     = 11'd1024;
  localparam logic [PER_W-1:0]   PER_RESET   = 11'd1;
  localparam logic [BYTES_W-1:0] BYTES_MAX   = 13'd4096;
  localparam logic [BYTES_W-1:0] BYTES_RESET = 13'd8;

  localparam int SLOT_COUNT_DEF = 1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PER_BLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REC_BYTES = 2'd1;

  // Request kinds
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  // Result status
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BEYOND = 2'd1;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  // Slot memory control
  typedef struct packed {
    logic rd;        // read both arrays at rd_addr
    logic live_wr;   // write live mark at wr_addr
    logic link_wr;   // write link at wr_addr
    logic live_bit;  // live mark value
  } mem_ctl_t;

endpackage

### src/rsfl_div.sv
// rsfl_div: restoring divider, one quotient bit per cycle.
// Depends on rsfl_pkg for the divisor width.
module rsfl_div
  import rsfl_pkg::*;
#(
  parameter int DW = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DW-1:0]    dividend,
  input  logic [PER_W-1:0] divisor,
  output logic             done,
  output logic [DW-1:0]    quotient,
  output logic [PER_W-1:0] remainder
);

  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [PER_W:0] trial;
  logic [PER_W:0] diff;
  logic           ge;

  assign trial = {remainder, quotient[DW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient register doubles as the dividend shifter
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[DW-2:0], ge};
      remainder <= ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
    end
  end

endmodule

### src/rsfl_mem.sv
// rsfl_mem: per-slot link and live-mark arrays, one read and one write port,
// registered read data. Depends on rsfl_pkg for mem_ctl_t.
module rsfl_mem
  import rsfl_pkg::*;
#(
  parameter int DEPTH = SLOT_COUNT_DEF,
  parameter int AW    = $clog2(SLOT_COUNT_DEF),
  parameter int LW    = $clog2(SLOT_COUNT_DEF + 1)
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  logic [LW-1:0] link_wdata,
  output logic [LW-1:0] link_rdata,
  output logic          live_rdata
);

  logic [LW-1:0] link_ram [DEPTH];
  logic          live_ram [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.link_wr) begin
      link_ram[wr_addr] <= link_wdata;
    end
    if (ctl.rd) begin
      link_rdata <= link_ram[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.live_wr) begin
      live_ram[wr_addr] <= ctl.live_bit;
    end
    if (ctl.rd) begin
      live_rdata <= live_ram[rd_addr];
    end
  end

endmodule

### src/record_slot_free_list.sv
// record_slot_free_list: top level, control sequencer, free-list state, output register.
// Depends on rsfl_pkg, rsfl_div, rsfl_mem.
//
// Usage
//   Requests enter on s_* (s_tuser = kind: insert, delete, lookup; s_tdata = slot id).
//   Each request yields exactly one result transaction on m_* carrying the slot id,
//   the data block index, the byte offset in the block, an appended-block flag,
//   a present flag and a status code.
//   Registers (slots per block, bytes per record) are written on the cfg_* channel,
//   which is ready whenever rst is low; write only while no request is in flight.
// Sequencing
//   One request at a time. A request that needs a location passes the divide, multiply
//   and commit steps (DW = max(10, clog2(SLOT_COUNT))); the bit-serial divider splits
//   the id into block and slot. The next request is accepted only once the result is
//   registered and the sequencer is back in its idle state, so a new request is never
//   taken before the last one is through. Mode 3 and inserts into a full store skip the
//   divider and the multiply step and go straight to the commit step.
// Reset and stalls
//   Reset empties the free list and restores the register defaults; no clearing pass
//   over the slot memory runs. Both input channels are held off while rst is high. A
//   stalled m_tready holds the result in the output register; the next request is still
//   accepted and worked on, and waits at its commit step until the output register
//   frees up.
module record_slot_free_list
  import rsfl_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // request stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,   // [9:0] slot_id, [15:10] zero
  input  logic [MODE_W-1:0]    s_tuser,   // [1:0] mode
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // [9:0] result_id, [20:10] block_index,
                                          // [42:21] byte_offset, [43] block_appended,
                                          // [44] present, [46:45] status, [47] zero
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int FH_W   = $clog2(SLOT_COUNT + 1);
  localparam int DW     = (IDX_W > ID_W) ? IDX_W : ID_W;
  localparam int PROD_W = ID_W + BYTES_W;
  localparam logic [FH_W-1:0] HEAD_LIM = FH_W'(SLOT_COUNT);
  localparam logic [DW:0]     SLOT_LIM = (DW + 1)'(SLOT_COUNT);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIV    = 4'b0010,
    S_MUL    = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state;

  // configuration
  logic [PER_W-1:0]   per_cfg;
  logic [BYTES_W-1:0] bytes_cfg;
  logic [PER_W-1:0]   per_eff;
  logic [BYTES_W-1:0] bytes_eff;

  // free-list state
  logic [FH_W-1:0]     free_head;
  logic [IDX_W-1:0]    highest_id;
  logic [FH_W-1:0]     live_count;
  logic [BLKCNT_W-1:0] block_count;
  logic                started;  // any insert done: slots 0..highest_id are written

  // request registers
  logic [MODE_W-1:0] mode_r;
  logic [DW-1:0]     target;
  logic              skip_r;
  logic [BLK_W-1:0]  blk_r;
  logic [OFF_W-1:0]  off_r;

  // intake
  logic              accept;
  logic [MODE_W-1:0] in_mode;
  logic [ID_W-1:0]   in_id;
  logic              head_full;
  logic              skip_in;
  logic [DW-1:0]     target_in;

  // divider
  logic             div_done;
  logic [DW-1:0]    quotient;
  logic [PER_W-1:0] remainder;
  logic [DW:0]      blk_sum;
  logic [PROD_W-1:0] prod;

  // memory
  mem_ctl_t        mem_ctl;
  logic [FH_W-1:0] link_rdata;
  logic            live_rdata;

  // commit
  logic             out_free;
  logic             commit;
  logic [IDX_W-1:0] take_idx;
  logic [IDX_W-1:0] highest_ins;
  logic [FH_W-1:0]  live_inc;
  logic             ins_fresh;
  logic             append;
  logic             beyond;
  logic             live_hit;
  logic             del_ok;

  logic [ID_W-1:0]  res_id;
  logic [BLK_W-1:0] res_blk;
  logic [OFF_W-1:0] res_off;
  logic             res_app;
  logic             res_pres;
  logic [ST_W-1:0]  res_st;

  // ---------------------------------------------------------------- config
  assign cfg_ready = !rst;

  assign per_eff = (per_cfg == '0)    ? PER_W'(1) :
                   (per_cfg > PER_MAX) ? PER_MAX   : per_cfg;
  assign bytes_eff = (bytes_cfg == '0)      ? BYTES_W'(1) :
                     (bytes_cfg > BYTES_MAX) ? BYTES_MAX   : bytes_cfg;

  // ---------------------------------------------------------------- intake
  assign s_tready  = (state == S_IDLE) && !rst;
  assign accept    = s_tvalid && s_tready;
  assign in_mode   = s_tuser;
  assign in_id     = s_tdata[ID_W-1:0];
  assign head_full = free_head >= HEAD_LIM;
  // unused kind, or insert with no slot left: no location work
  assign skip_in   = !(in_mode inside {MODE_INSERT, MODE_DELETE, MODE_LOOKUP}) ||
                     (in_mode == MODE_INSERT && head_full);
  assign target_in = (in_mode == MODE_INSERT) ? DW'(free_head[IDX_W-1:0]) : DW'(in_id);

  // ---------------------------------------------------------------- divide / scale
  rsfl_div #(
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && !skip_in),
    .dividend  (target_in),
    .divisor   (per_eff),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  assign blk_sum = {1'b0, quotient} + (DW + 1)'(1);
  assign prod    = PROD_W'(remainder[ID_W-1:0]) * PROD_W'(bytes_eff);

  // ---------------------------------------------------------------- slot memory
  // read issued with the request, data held until the commit step
  assign take_idx = target[IDX_W-1:0];

  assign mem_ctl.rd       = accept && !skip_in;
  assign mem_ctl.live_wr  = commit && ((mode_r == MODE_INSERT && !skip_r) ||
                                       (mode_r == MODE_DELETE && del_ok));
  assign mem_ctl.link_wr  = commit && mode_r == MODE_DELETE && del_ok;
  assign mem_ctl.live_bit = (mode_r == MODE_INSERT);

  rsfl_mem #(
    .DEPTH (SLOT_COUNT),
    .AW    (IDX_W),
    .LW    (FH_W)
  ) u_mem (
    .clk        (clk),
    .ctl        (mem_ctl),
    .rd_addr    (target_in[IDX_W-1:0]),
    .wr_addr    (take_idx),
    .link_wdata (free_head),
    .link_rdata (link_rdata),
    .live_rdata (live_rdata)
  );

  // ---------------------------------------------------------------- commit
  assign out_free = !m_tvalid || m_tready;
  assign commit   = (state == S_COMMIT) && out_free;

  assign highest_ins = (take_idx > highest_id) ? take_idx : highest_id;
  assign live_inc    = live_count + FH_W'(1);
  // no holes left: next fresh id follows the taken one
  assign ins_fresh   = live_inc == (FH_W'(highest_ins) + FH_W'(1));
  assign append      = {1'b0, blk_r} >= block_count;

  assign beyond   = ({1'b0, target} > (DW + 1)'(highest_id)) || ({1'b0, target} >= SLOT_LIM);
  // entries above highest_id are never live and are caught by beyond;
  // below it they are written once started is set
  assign live_hit = started && live_rdata;
  assign del_ok   = !beyond && live_hit;

  always_comb begin
    res_id   = '0;
    res_blk  = '0;
    res_off  = '0;
    res_app  = 1'b0;
    res_pres = 1'b0;
    res_st   = ST_OK;
    case (mode_r)
      MODE_INSERT: begin
        if (skip_r) begin
          res_st = ST_FULL;
        end else begin
          res_id  = target[ID_W-1:0];
          res_blk = blk_r;
          res_off = off_r;
          res_app = append;
        end
      end
      MODE_DELETE, MODE_LOOKUP: begin
        res_id  = target[ID_W-1:0];
        res_blk = blk_r;
        res_off = off_r;
        if (beyond) begin
          res_st = ST_BEYOND;
        end else if (!live_hit) begin
          res_st = ST_ABSENT;
        end else begin
          res_pres = (mode_r == MODE_LOOKUP);
        end
      end
      default: begin
        res_st = ST_OK;
      end
    endcase
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      per_cfg     <= PER_RESET;
      bytes_cfg   <= BYTES_RESET;
      free_head   <= '0;
      highest_id  <= '0;
      live_count  <= '0;
      block_count <= BLKCNT_W'(1);
      started     <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PER_BLOCK: per_cfg   <= cfg_data[PER_W-1:0];
          REG_REC_BYTES: bytes_cfg <= cfg_data[BYTES_W-1:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= skip_in ? S_COMMIT : S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
            if (mode_r == MODE_INSERT && !skip_r) begin
              started    <= 1'b1;
              highest_id <= highest_ins;
              live_count <= live_inc;
              free_head  <= ins_fresh ? (FH_W'(take_idx) + FH_W'(1)) : link_rdata;
              if (append) begin
                block_count <= block_count + BLKCNT_W'(1);
              end
            end else if (mode_r == MODE_DELETE && del_ok) begin
              free_head  <= FH_W'(take_idx);
              live_count <= live_count - FH_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      target <= target_in;
      skip_r <= skip_in;
    end
    if (state == S_MUL) begin
      blk_r <= blk_sum[BLK_W-1:0];
      off_r <= prod[OFF_W-1:0];
    end
    if (commit) begin
      m_tdata <= {1'b0, res_st, res_pres, res_app, res_off, res_blk, res_id};
    end
  end

  // ---------------------------------------------------------------- assertions
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    free_head <= HEAD_LIM)
    else $error("free list head beyond slot count");

  a_highest_range: assert property (@(posedge clk) disable iff (rst)
    FH_W'(highest_id) < HEAD_LIM)
    else $error("highest id beyond slot count");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

  a_commit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && !out_free) |=> (state == S_COMMIT && m_tvalid))
    else $error("commit left while the output register was still full");

endmodule
